// ===== hdl/gbw_pkg.sv =====
// shared types and constants of the glyph blitter
`default_nettype none
package gbw_pkg;

  // font store geometry: eight row bytes per glyph
  localparam int FONT_DEPTH = 768;
  localparam int FONT_AW    = 10;

  // input operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // draw sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ROW,
    ST_SECOND
  } state_t;

  // clamped draw request handed to the sequencer
  typedef struct packed {
    logic [7:0] glyph;
    logic [7:0] line0;
    logic [3:0] col;
    logic [3:0] offs;
  } draw_req_t;

  // one masked word write
  typedef struct packed {
    logic [15:0] address;
    logic [15:0] data;
    logic [15:0] mask;
    logic        last;
  } word_t;

endpackage
`default_nettype wire

// ===== hdl/gbw_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none
module gbw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hdl/gbw_engine.sv =====
// row sequencer with one shared shifter that turns glyph rows into word writes
`default_nettype none
module gbw_engine #(
  parameter int WORDS_PER_LINE = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       go,
  input  wire gbw_pkg::draw_req_t         req_in,
  input  wire logic [15:0]                base,
  output logic      [gbw_pkg::FONT_AW-1:0] rd_addr,
  input  wire logic [7:0]                 rd_data,
  output logic                            busy,
  output logic                            valid,
  output gbw_pkg::word_t                  word
);
  import gbw_pkg::*;

  localparam logic [15:0] WPL = 16'(WORDS_PER_LINE);

  state_t      state, state_next;
  draw_req_t   req;
  logic [2:0]  row;
  logic [15:0] addr;
  logic [15:0] hold_data;
  logic [15:0] hold_mask;
  logic        zero;

  logic        straddle;
  logic        last_row;
  logic [7:0]  row_bits;
  logic [31:0] shifted_data;
  logic [31:0] shifted_mask;
  logic [2:0]  rd_row;
  logic [10:0] rd_full;
  logic        emit;
  logic        row_done;
  word_t       word_next;

  assign straddle = req.offs > 4'd8;
  assign last_row = row == 3'd7;
  assign busy     = state != ST_IDLE;

  // shared shifter: glyph row placed across a left and a right word
  assign row_bits     = zero ? 8'h00 : rd_data;
  assign shifted_data = {row_bits, 24'h000000} >> req.offs;
  assign shifted_mask = {8'hff, 24'h000000} >> req.offs;

  // font read runs one row ahead of the emitted row
  assign rd_row  = (state == ST_SETUP) ? 3'd0 : row + 3'd1;
  assign rd_full = {req.glyph, rd_row};
  assign rd_addr = rd_full[FONT_AW-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (go) state_next = ST_SETUP;
      end
      ST_SETUP: state_next = ST_ROW;
      ST_ROW: begin
        if (straddle) state_next = ST_SECOND;
        else if (last_row) state_next = ST_IDLE;
        else state_next = ST_ROW;
      end
      ST_SECOND: state_next = last_row ? ST_IDLE : ST_ROW;
      default: state_next = ST_IDLE;
    endcase
  end

  // word selection per state
  always_comb begin
    emit      = 1'b0;
    row_done  = 1'b0;
    word_next = word;
    unique case (state)
      ST_ROW: begin
        emit              = 1'b1;
        row_done          = !straddle;
        word_next.address = addr;
        word_next.data    = shifted_data[31:16];
        word_next.mask    = shifted_mask[31:16];
        word_next.last    = !straddle && last_row;
      end
      ST_SECOND: begin
        emit              = 1'b1;
        row_done          = 1'b1;
        word_next.address = addr + 16'd1;
        word_next.data    = hold_data;
        word_next.mask    = hold_mask;
        word_next.last    = last_row;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= 1'b0;
      row   <= 3'd0;
    end else begin
      state <= state_next;
      valid <= emit;
      if (state == ST_SETUP) row <= 3'd0;
      else if (row_done) row <= row + 3'd1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (go && state == ST_IDLE) req <= req_in;
    zero <= rd_full >= 11'(FONT_DEPTH);
    if (state == ST_SETUP) begin
      addr <= base + 16'(req.line0) * WPL + 16'(req.col);
    end else if (row_done) begin
      addr <= addr + WPL;
    end
    if (state == ST_ROW) begin
      hold_data <= shifted_data[15:0];
      hold_mask <= shifted_mask[15:0];
    end
    if (emit) word <= word_next;
  end

`ifndef NO_ASSERTIONS
  a_strobe_from_work: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(state == ST_ROW || state == ST_SECOND))
    else $error("word strobe without an emitting state");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (valid && word.last) |=> !valid)
    else $error("word strobe right after the final word");
  a_go_setup: assert property (@(posedge clk) disable iff (rst)
    (go && state == ST_IDLE) |=> state == ST_SETUP)
    else $error("draw not started");
  a_second_after_row: assert property (@(posedge clk) disable iff (rst)
    state == ST_SECOND |-> $past(state == ST_ROW))
    else $error("right word without left word");
`endif

endmodule
`default_nettype wire

// ===== hdl/glyph_blit_to_word_framebuffer.sv =====
// top level of the 8x8 glyph blitter onto a 16-bit word frame buffer
//
// Input channel: an item is taken at a rising edge with start high and busy
// low. op selects a load (one font row byte into the 768-byte font store) or
// a draw (one character at pixel x, y, y counted from the bottom).
// A load gives no words; busy stays low.
// A draw keeps busy high through a setup state that forms the first line
// address, then through the word writes: one per row when the glyph sits in
// one word column, two when it straddles a word boundary. The font read port
// runs one row ahead of the shifter, so the rate is set by the single
// result port: one word per cycle, 8 or 16 words per character.
// The first word is registered after the setup state, top row first.
// Result channel: each word is on word_address, write_data, write_mask and
// last for one cycle with strobe high; the receiver cannot stall it.
// Configuration: cfg_write with cfg_data loads the frame base word address;
// write it only while the block is idle; the block does not enforce this.
// Reset clears the sequencer and the base register; the font store is not
// cleared and a row must be loaded before any character uses it.
`default_nettype none
module glyph_blit_to_word_framebuffer #(
  parameter int H_PIXELS       = 256,
  parameter int V_LINES        = 192,
  parameter int WORDS_PER_LINE = 16,
  parameter int FIRST_CODE     = 32,
  parameter int GLYPH_COUNT    = 96
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        op,
  input  wire logic [7:0]  char_code,
  input  wire logic [7:0]  pos_x,
  input  wire logic [7:0]  pos_y,
  input  wire logic [9:0]  font_address,
  input  wire logic [7:0]  font_row_bits,
  input  wire logic        cfg_write,
  input  wire logic [15:0] cfg_data,
  output logic             strobe,
  output logic [15:0]      word_address,
  output logic [15:0]      write_data,
  output logic [15:0]      write_mask,
  output logic             last
);
  import gbw_pkg::*;

  localparam logic [7:0] X_MAX      = 8'(H_PIXELS - 8);
  localparam logic [7:0] Y_MAX      = 8'(V_LINES - 8);
  localparam logic [7:0] CODE_OFFS  = 8'(FIRST_CODE);
  localparam logic [7:0] GLYPH_LAST = 8'(GLYPH_COUNT - 1);
  localparam logic [8:0] GLYPH_NUM  = 9'(GLYPH_COUNT);

  logic [15:0]        frame_base_word;
  logic               accept;
  logic               load_we;
  logic               go;
  logic [7:0]         glyph_raw;
  logic [7:0]         x_clamped;
  logic [7:0]         y_clamped;
  draw_req_t          req;
  logic [FONT_AW-1:0] rd_addr;
  logic [7:0]         rd_data;
  word_t              word;

  // input handshake and load decode
  assign accept  = start && !busy;
  assign load_we = accept && op == OP_LOAD && font_address < 10'(FONT_DEPTH);
  assign go      = accept && op == OP_DRAW;

  // code mapping and position clamp
  assign glyph_raw = char_code - CODE_OFFS;
  assign x_clamped = (pos_x >= X_MAX) ? X_MAX : pos_x;
  assign y_clamped = (pos_y >= Y_MAX) ? Y_MAX : pos_y;
  assign req.glyph = ({1'b0, glyph_raw} >= GLYPH_NUM) ? GLYPH_LAST : glyph_raw;
  assign req.line0 = Y_MAX - y_clamped;
  assign req.col   = x_clamped[7:4];
  assign req.offs  = x_clamped[3:0];

  // frame base register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base_word <= 16'h0000;
    end else if (cfg_write) begin
      frame_base_word <= cfg_data;
    end
  end

  // font store
  gbw_ram #(
    .WIDTH (8),
    .DEPTH (FONT_DEPTH)
  ) u_font (
    .clk     (clk),
    .we      (load_we),
    .wr_addr (font_address),
    .wr_data (font_row_bits),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // row sequencer
  gbw_engine #(
    .WORDS_PER_LINE (WORDS_PER_LINE)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .req_in  (req),
    .base    (frame_base_word),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .busy    (busy),
    .valid   (strobe),
    .word    (word)
  );

  assign word_address = word.address;
  assign write_data   = word.data;
  assign write_mask   = word.mask;
  assign last         = word.last;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// testbench for the glyph blitter: font loads, character draws, masked word checks
`timescale 1ns / 100ps
module tb_top;
  import gbw_pkg::*;

  // block parameters as instantiated
  localparam int H_PIXELS       = 256;
  localparam int V_LINES        = 192;
  localparam int WORDS_PER_LINE = 16;
  localparam int FIRST_CODE     = 32;
  localparam int GLYPH_COUNT    = 96;
  localparam int SETTLE_CYCLES  = 20;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        op;
  logic [7:0]  char_code;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [9:0]  font_address;
  logic [7:0]  font_row_bits;
  logic        cfg_write;
  logic [15:0] cfg_data;
  logic        strobe;
  logic [15:0] word_address;
  logic [15:0] write_data;
  logic [15:0] write_mask;
  logic        last;

  // shadow of the font store and the base register
  logic [7:0]            font_shadow [FONT_DEPTH];
  logic [FONT_DEPTH-1:0] row_written;
  logic [15:0]           base_shadow;

  // words still to come, oldest first
  word_t pending_words [$];
  int    errors;

  glyph_blit_to_word_framebuffer #(
    .H_PIXELS(H_PIXELS),
    .V_LINES(V_LINES),
    .WORDS_PER_LINE(WORDS_PER_LINE),
    .FIRST_CODE(FIRST_CODE),
    .GLYPH_COUNT(GLYPH_COUNT)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .char_code(char_code),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .font_address(font_address),
    .font_row_bits(font_row_bits),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .strobe(strobe),
    .word_address(word_address),
    .write_data(write_data),
    .write_mask(write_mask),
    .last(last)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // work out the words of one accepted item, or update the font shadow
  task automatic render_glyph_words(input logic op_i, input logic [7:0] code,
                                    input logic [7:0] x, input logic [7:0] y,
                                    input logic [9:0] fa, input logic [7:0] fb);
    logic [7:0]  glyph;
    logic [7:0]  cx;
    logic [7:0]  cy;
    logic [7:0]  line0;
    logic [7:0]  bits;
    logic [3:0]  col;
    logic [3:0]  offs;
    logic [15:0] addr;
    logic [15:0] row_pix;
    int          fidx;
    int          s;
    word_t       w;
    if (op_i == OP_LOAD) begin
      if (fa < FONT_DEPTH) begin
        font_shadow[fa] = fb;
        row_written[fa] = 1'b1;
      end
      return;
    end
    // code to glyph, clamping anything past the font
    glyph = code - 8'(FIRST_CODE);
    if (glyph >= GLYPH_COUNT) glyph = 8'(GLYPH_COUNT - 1);
    // position clamp, y counted from the bottom
    cx = (x >= H_PIXELS - 8) ? 8'(H_PIXELS - 8) : x;
    cy = (y >= V_LINES - 8) ? 8'(V_LINES - 8) : y;
    line0 = 8'(V_LINES - 8) - cy;
    col = cx[7:4];
    offs = cx[3:0];
    for (int row = 0; row < 8; row++) begin
      fidx = int'(glyph) * 8 + row;
      bits = (fidx < FONT_DEPTH) ? font_shadow[fidx] : 8'h00;
      row_pix = {8'h00, bits};
      addr = 16'(int'(base_shadow) + (int'(line0) + row) * WORDS_PER_LINE + int'(col));
      if (offs <= 8) begin
        w.address = addr;
        w.data = 16'(row_pix << (8 - offs));
        w.mask = 16'(16'h00ff << (8 - offs));
        w.last = (row == 7);
        pending_words.push_back(w);
      end else begin
        // straddles a word boundary: left word, then right word
        s = offs - 8;
        w.address = addr;
        w.data = row_pix >> s;
        w.mask = 16'h00ff >> s;
        w.last = 1'b0;
        pending_words.push_back(w);
        w.address = addr + 16'd1;
        w.data = 16'(row_pix << (16 - s));
        w.mask = 16'(16'h00ff << (16 - s));
        w.last = (row == 7);
        pending_words.push_back(w);
      end
    end
  endtask

  // keep start low with noise on the fields
  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
      op <= 1'($urandom);
      char_code <= 8'($urandom);
      pos_x <= 8'($urandom);
      pos_y <= 8'($urandom);
      font_address <= 10'($urandom);
      font_row_bits <= 8'($urandom);
    end
  endtask

  // offer one item and wait for the accepting edge; start stays high after
  task automatic issue_item(input logic op_i, input logic [7:0] code,
                            input logic [7:0] x, input logic [7:0] y,
                            input logic [9:0] fa, input logic [7:0] fb);
    @(negedge clk);
    start <= 1'b1;
    op <= op_i;
    char_code <= code;
    pos_x <= x;
    pos_y <= y;
    font_address <= fa;
    font_row_bits <= fb;
    do @(posedge clk); while (busy);
    render_glyph_words(op_i, code, x, y, fa, fb);
  endtask

  task automatic load_row(input logic [9:0] fa, input logic [7:0] fb);
    issue_item(OP_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), fa, fb);
  endtask

  task automatic draw_char(input logic [7:0] code, input logic [7:0] x,
                           input logic [7:0] y);
    issue_item(OP_DRAW, code, x, y, 10'($urandom), 8'($urandom));
  endtask

  // drop start, wait for every word, then let the block settle
  task automatic wait_idle();
    hold_off(1);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame_base(input logic [15:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_data <= 16'($urandom);
    base_shadow = value;
  endtask

  // first and last glyphs, edge row patterns, loads past the store
  task automatic test_font_load();
    logic [7:0] first_rows [8];
    first_rows = '{8'hff, 8'h00, 8'h81, 8'h80, 8'h01, 8'haa, 8'h55, 8'h3c};
    for (int r = 0; r < 8; r++) load_row(10'(r), first_rows[r]);
    for (int r = 0; r < 8; r++) load_row(10'((GLYPH_COUNT - 1) * 8 + r), 8'h01 << r);
    // these must leave the store alone
    load_row(10'd768, 8'hff);
    load_row(10'h3ff, 8'hff);
  endtask

  // code mapping and position clamp corners
  task automatic test_code_and_position();
    draw_char(8'(FIRST_CODE), 8'd0, 8'd0);
    draw_char(8'(FIRST_CODE + GLYPH_COUNT - 1), 8'd255, 8'd255);
    // index equal to the count still clamps
    draw_char(8'(FIRST_CODE + GLYPH_COUNT), 8'd8, 8'd184);
    draw_char(8'(FIRST_CODE - 1), 8'd9, 8'd100);
    draw_char(8'd0, 8'd7, 8'd185);
    draw_char(8'd255, 8'd248, 8'd1);
    wait_idle();
  endtask

  // random loads and draws over a given base
  task automatic test_random_phase(input logic [15:0] base, input int n_items,
                                   input bit idling);
    int          done_items;
    int          pick;
    int          g;
    int          rows_to_load;
    logic [9:0]  fa;
    logic [7:0]  fb;
    logic [7:0]  code;
    logic [7:0]  x;
    int          ready [$];
    set_frame_base(base);
    done_items = 0;
    while (done_items < n_items) begin
      if (idling && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 3));
      ready.delete();
      for (int k = 0; k < GLYPH_COUNT; k++)
        if (&row_written[k*8 +: 8]) ready.push_back(k);
      pick = $urandom_range(0, 9);
      if (ready.size() == 0 || pick < 2) begin
        // glyph load sequence, sometimes cut short
        g = $urandom_range(0, GLYPH_COUNT - 1);
        rows_to_load = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 8;
        for (int r = 0; r < rows_to_load; r++) begin
          if (idling && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 3));
          case ($urandom_range(0, 7))
            0: fb = 8'h00;
            1: fb = 8'hff;
            default: fb = 8'($urandom);
          endcase
          load_row(10'(g * 8 + r), fb);
        end
        done_items += rows_to_load;
      end else if (pick == 2) begin
        // stray load anywhere, past the store included
        fa = 10'($urandom_range(0, 1023));
        load_row(fa, 8'($urandom));
        if (fa < FONT_DEPTH) done_items++;
      end else begin
        g = ready[$urandom_range(0, ready.size() - 1)];
        if (g == GLYPH_COUNT - 1 && $urandom_range(0, 1) == 0)
          code = 8'($urandom_range(0, 159) + 128);
        else
          code = 8'(g + FIRST_CODE);
        x = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(240, 255))
                                        : 8'($urandom_range(0, 255));
        draw_char(code, x, 8'($urandom_range(0, 255)));
        done_items++;
      end
    end
    wait_idle();
  endtask

  // compare each word with the oldest expectation
  always @(posedge clk) begin : check_words
    word_t exp_w;
    if (!rst && strobe) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word addr %h data %h mask %h last %b",
                 $time, word_address, write_data, write_mask, last);
        errors++;
      end else begin
        exp_w = pending_words.pop_front();
        if (word_address !== exp_w.address) begin
          $display("%0t: word_address expected %h actual %h",
                   $time, exp_w.address, word_address);
          errors++;
        end
        if (write_data !== exp_w.data) begin
          $display("%0t: write_data expected %h actual %h", $time, exp_w.data, write_data);
          errors++;
        end
        if (write_mask !== exp_w.mask) begin
          $display("%0t: write_mask expected %h actual %h", $time, exp_w.mask, write_mask);
          errors++;
        end
        if (last !== exp_w.last) begin
          $display("%0t: last expected %b actual %b", $time, exp_w.last, last);
          errors++;
        end
      end
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("glyph_blit_to_word_framebuffer: mismatch");
    $finish;
  end

  // test sequence
  initial begin
    errors = 0;
    base_shadow = 16'h0000;
    row_written = '0;
    rst = 1'b1;
    start = 1'b0;
    op = OP_LOAD;
    char_code = 8'h00;
    pos_x = 8'h00;
    pos_y = 8'h00;
    font_address = 10'h000;
    font_row_bits = 8'h00;
    cfg_write = 1'b0;
    cfg_data = 16'h0000;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_frame_base(16'h0000);
    test_font_load();
    test_code_and_position();
    test_random_phase(16'hffff, 70, 1'b1);
    test_random_phase(16'($urandom), 70, 1'b1);
    test_random_phase(16'hfff0, 70, 1'b1);
    test_random_phase(16'h0000, 70, 1'b0);
    if (errors == 0)
      $display("glyph_blit_to_word_framebuffer: match");
    else
      $display("glyph_blit_to_word_framebuffer: mismatch");
    $finish;
  end

endmodule
